/* rtl/vlcd_pkg.sv */
// Shared types and constants for the variable-length code table decoder.
// No dependencies.
package vlcd_pkg;

	localparam int TABLE_DEPTH = 256;
	localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int MAX_LEN     = 32;
	localparam int CODE_W      = 32;
	localparam int LEN_W       = 6;
	localparam int VAL_W       = 16;
	localparam int COUNT_W     = 9;
	localparam int CFG_W       = 9;

	typedef enum logic {
		OP_LOAD   = 1'b0,
		OP_DECODE = 1'b1
	} opcode_t;

	typedef enum logic {
		CFG_ENTRY_COUNT   = 1'b0,
		CFG_SEARCH_LENGTH = 1'b1
	} cfg_index_t;

	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_NO_MATCH = 2'd1,
		STAT_LEN_ERR  = 2'd2
	} status_t;

	typedef struct packed {
		logic [CODE_W-1:0]       code;
		logic [LEN_W-1:0]        length;
		logic signed [VAL_W-1:0] value;
	} entry_t;

endpackage

/* rtl/vlcd_table.sv */
// Code table storage: one write port, one read port, registered read data.
// Depends on vlcd_pkg.
module vlcd_table import vlcd_pkg::*; (
	input  logic             clk,
	input  logic             we,
	input  logic [IDX_W-1:0] waddr,
	input  entry_t           wdata,
	input  logic             re,
	input  logic [IDX_W-1:0] raddr,
	output entry_t           rdata
);

	entry_t mem [TABLE_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/vlc_table_symbol_decoder.sv */
// Top level of the variable-length code table decoder: control, scan and result register.
// Depends on vlcd_pkg and vlcd_table.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one word per item. opcode OP_LOAD
//   writes table slot entry_index with entry_code, entry_length and entry_value;
//   opcode OP_DECODE aligns window by bit_offset and searches the table.
//   Output channel (out_valid / out_stall) returns one result word per item.
//   Configuration: cfg_we with cfg_index selects entry_count or search_length;
//   write only while the block is idle.
// Operation:
//   A load goes straight to the hand-off of its result. A decode reads
//   slots 0..N-1 of the table, one slot per cycle through the single read
//   port, where N is entry_count clamped to the table depth; when N is 0 it
//   reads none and goes straight to the hand-off. One item is in work at a
//   time; the next item is accepted the cycle after the result is handed to
//   the output register. The hand-off waits while the output register
//   holds a result the receiver has not taken.
// Reset:
//   arst_n clears control state, sets entry_count to 0 and search_length to
//   32. Table contents are undefined until loaded.
// Stall:
//   While out_stall holds the output word, a finished result waits in the
//   block and in_stall stays high until the output register frees.
module vlc_table_symbol_decoder import vlcd_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [0:0]              cfg_index,
	input  logic [CFG_W-1:0]        cfg_data,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic                    opcode,
	input  logic [7:0]              entry_index,
	input  logic [CODE_W-1:0]       entry_code,
	input  logic [LEN_W-1:0]        entry_length,
	input  logic signed [VAL_W-1:0] entry_value,
	input  logic [31:0]             window,
	input  logic [2:0]              bit_offset,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [VAL_W-1:0] decoded_value,
	output logic [LEN_W-1:0]        code_length,
	output logic [2:0]              byte_advance,
	output logic [2:0]              next_offset,
	output logic [1:0]              status
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	state_t                  state_q;
	logic [COUNT_W-1:0]      entry_count_q;
	logic [LEN_W-1:0]        search_length_q;
	logic [CODE_W-1:0]       aligned_q;
	logic [2:0]              offset_q;
	logic [LEN_W-1:0]        limit_q;
	logic [CNT_W-1:0]        active_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    found_q;
	logic [LEN_W-1:0]        best_len_q;
	logic signed [VAL_W-1:0] best_val_q;
	logic                    valid_s1;
	logic                    last_s1;
	logic signed [VAL_W-1:0] pend_value_q;
	logic [LEN_W-1:0]        pend_len_q;
	logic [2:0]              pend_adv_q;
	logic [2:0]              pend_off_q;
	status_t                 pend_status_q;
	logic                    out_valid_q;
	logic signed [VAL_W-1:0] out_value_q;
	logic [LEN_W-1:0]        out_len_q;
	logic [2:0]              out_adv_q;
	logic [2:0]              out_off_q;
	status_t                 out_status_q;

	logic                    in_acc;
	logic                    out_free;
	logic                    load_len_ok;
	logic                    wr_en;
	entry_t                  wr_data;
	logic [CNT_W-1:0]        active_in;
	logic [LEN_W-1:0]        limit_in;
	logic                    rd_en;
	logic                    rd_last;
	logic [IDX_W-1:0]        rd_addr;
	entry_t                  rd_data;
	logic                    len_ok;
	logic [CODE_W-1:0]       top_bits;
	logic                    hit;
	logic                    better;
	logic                    nxt_found;
	logic [LEN_W-1:0]        nxt_len;
	logic signed [VAL_W-1:0] nxt_val;
	logic [LEN_W-1:0]        total;

	always_comb begin
		in_acc      = in_valid && (state_q == ST_IDLE);
		out_free    = !out_valid_q || !out_stall;
		load_len_ok = int'(entry_length) <= MAX_LEN;
		wr_en       = in_acc && (opcode == OP_LOAD) && load_len_ok
			&& (int'(entry_index) < TABLE_DEPTH);
		wr_data     = '{code: entry_code, length: entry_length, value: entry_value};
		active_in   = (int'(entry_count_q) > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH)
			: CNT_W'(entry_count_q);
		limit_in    = (int'(search_length_q) > MAX_LEN) ? LEN_W'(MAX_LEN) : search_length_q;
		rd_en       = 1'b0;
		rd_last     = 1'b0;
		rd_addr     = '0;
		if (in_acc && (opcode == OP_DECODE) && (active_in != '0)) begin
			rd_en   = 1'b1;
			rd_last = (active_in == CNT_W'(1));
		end else if ((state_q == ST_SCAN) && (cnt_q < active_q)) begin
			rd_en   = 1'b1;
			rd_addr = cnt_q[IDX_W-1:0];
			rd_last = ((cnt_q + CNT_W'(1)) == active_q);
		end
	end

	vlcd_table u_table (
		.clk   (clk),
		.we    (wr_en),
		.waddr (IDX_W'(entry_index)),
		.wdata (wr_data),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	always_comb begin
		len_ok    = (rd_data.length != '0) && (rd_data.length <= limit_q);
		top_bits  = aligned_q >> (LEN_W'(MAX_LEN) - rd_data.length);
		hit       = len_ok && (top_bits == rd_data.code);
		better    = hit && (!found_q || (rd_data.length < best_len_q));
		nxt_found = found_q || hit;
		nxt_len   = better ? rd_data.length : best_len_q;
		nxt_val   = better ? rd_data.value : best_val_q;
		total     = nxt_len + LEN_W'(offset_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			entry_count_q   <= '0;
			search_length_q <= LEN_W'(MAX_LEN);
			aligned_q       <= '0;
			offset_q        <= '0;
			limit_q         <= '0;
			active_q        <= '0;
			cnt_q           <= '0;
			found_q         <= 1'b0;
			best_len_q      <= '0;
			best_val_q      <= '0;
			valid_s1        <= 1'b0;
			last_s1         <= 1'b0;
			pend_value_q    <= '0;
			pend_len_q      <= '0;
			pend_adv_q      <= '0;
			pend_off_q      <= '0;
			pend_status_q   <= STAT_OK;
			out_valid_q     <= 1'b0;
			out_value_q     <= '0;
			out_len_q       <= '0;
			out_adv_q       <= '0;
			out_off_q       <= '0;
			out_status_q    <= STAT_OK;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index_t'(cfg_index))
					CFG_ENTRY_COUNT:   entry_count_q   <= COUNT_W'(cfg_data);
					CFG_SEARCH_LENGTH: search_length_q <= cfg_data[LEN_W-1:0];
					default: ;
				endcase
			end
			if ((state_q == ST_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			valid_s1 <= rd_en;
			last_s1  <= rd_last;
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						pend_value_q <= '0;
						pend_len_q   <= '0;
						pend_adv_q   <= '0;
						pend_off_q   <= '0;
						if (opcode == OP_LOAD) begin
							pend_status_q <= load_len_ok ? STAT_OK : STAT_LEN_ERR;
							state_q       <= ST_DONE;
						end else begin
							aligned_q  <= window << bit_offset;
							offset_q   <= bit_offset;
							limit_q    <= limit_in;
							active_q   <= active_in;
							cnt_q      <= CNT_W'(1);
							found_q    <= 1'b0;
							best_len_q <= '0;
							best_val_q <= '0;
							if (active_in == '0) begin
								pend_status_q <= STAT_NO_MATCH;
								state_q       <= ST_DONE;
							end else begin
								state_q <= ST_SCAN;
							end
						end
					end
				end
				ST_SCAN: begin
					if (rd_en) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
					if (valid_s1) begin
						found_q    <= nxt_found;
						best_len_q <= nxt_len;
						best_val_q <= nxt_val;
						if (last_s1) begin
							state_q <= ST_DONE;
							if (nxt_found) begin
								pend_value_q  <= nxt_val;
								pend_len_q    <= nxt_len;
								pend_adv_q    <= total[5:3];
								pend_off_q    <= total[2:0];
								pend_status_q <= STAT_OK;
							end else begin
								pend_value_q  <= '0;
								pend_len_q    <= '0;
								pend_adv_q    <= '0;
								pend_off_q    <= '0;
								pend_status_q <= STAT_NO_MATCH;
							end
						end
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_value_q  <= pend_value_q;
						out_len_q    <= pend_len_q;
						out_adv_q    <= pend_adv_q;
						out_off_q    <= pend_off_q;
						out_status_q <= pend_status_q;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_stall      = (state_q != ST_IDLE);
	assign out_valid     = out_valid_q;
	assign decoded_value = out_value_q;
	assign code_length   = out_len_q;
	assign byte_advance  = out_adv_q;
	assign next_offset   = out_off_q;
	assign status        = out_status_q;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q != ST_IDLE))
		else $error("accepted word did not start work");

	a_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == ST_IDLE))
		else $error("table write outside idle");

	a_read_scan: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (state_q == ST_SCAN))
		else $error("table read data outside scan");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (cnt_q <= active_q))
		else $error("scan counter beyond active entries");

	a_nomatch_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_status_q == STAT_NO_MATCH)) |->
			((out_len_q == '0) && (out_value_q == '0)))
		else $error("no-match result carries data");

endmodule

/* dv/vlcd_checker.sv */
`timescale 1ns / 1ps
// Checker for the VLC table decoder: snoops the config port and both word channels,
// predicts each result from its own copy of the code table and compares in order.
// Depends on vlcd_pkg.
module vlcd_checker import vlcd_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [0:0]              cfg_index,
	input  logic [CFG_W-1:0]        cfg_data,
	input  logic                    in_valid,
	input  logic                    in_stall,
	input  logic                    opcode,
	input  logic [7:0]              entry_index,
	input  logic [CODE_W-1:0]       entry_code,
	input  logic [LEN_W-1:0]        entry_length,
	input  logic signed [VAL_W-1:0] entry_value,
	input  logic [31:0]             window,
	input  logic [2:0]              bit_offset,
	input  logic                    out_valid,
	input  logic                    out_stall,
	input  logic signed [VAL_W-1:0] decoded_value,
	input  logic [LEN_W-1:0]        code_length,
	input  logic [2:0]              byte_advance,
	input  logic [2:0]              next_offset,
	input  logic [1:0]              status,
	output int unsigned             errors,
	output int unsigned             pending
);

	typedef struct packed {
		logic signed [VAL_W-1:0] value;
		logic [LEN_W-1:0]        length;
		logic [2:0]              advance;
		logic [2:0]              offset;
		status_t                 stat;
	} symbol_t;

	entry_t             slots [TABLE_DEPTH];
	logic [COUNT_W-1:0] active_count;
	logic [LEN_W-1:0]   search_len;
	symbol_t            symbol_q [$];
	int unsigned        err_cnt;

	function automatic symbol_t lookup_symbol(logic [31:0] win, logic [2:0] shift);
		logic [31:0] aligned;
		int          active;
		int          limit;
		int          len;
		logic        hit;
		logic [6:0]  total;
		symbol_t     res;
		aligned  = win << shift;
		active   = (active_count > TABLE_DEPTH) ? TABLE_DEPTH : active_count;
		limit    = (search_len > MAX_LEN) ? MAX_LEN : search_len;
		hit      = 1'b0;
		res      = '0;
		res.stat = STAT_NO_MATCH;
		// shortest length wins, lowest slot on a tie
		for (int i = 0; i < active; i++) begin
			len = slots[i].length;
			if (len != 0 && len <= limit && (aligned >> (MAX_LEN - len)) == slots[i].code
					&& (!hit || len < res.length)) begin
				hit        = 1'b1;
				res.value  = slots[i].value;
				res.length = LEN_W'(len);
			end
		end
		if (hit) begin
			total       = res.length + shift;
			res.advance = total[5:3];
			res.offset  = total[2:0];
			res.stat    = STAT_OK;
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		symbol_t want;
		if (!arst_n) begin
			active_count = '0;
			search_len   = LEN_W'(MAX_LEN);
			err_cnt      = 0;
			symbol_q.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (symbol_q.size() == 0) begin
					$error("result word with nothing outstanding: status %0d", status);
					err_cnt++;
				end else begin
					want = symbol_q.pop_front();
					if (decoded_value !== want.value) begin
						$error("decoded_value: expected %0d, got %0d", want.value, decoded_value);
						err_cnt++;
					end
					if (code_length !== want.length) begin
						$error("code_length: expected %0d, got %0d", want.length, code_length);
						err_cnt++;
					end
					if (byte_advance !== want.advance) begin
						$error("byte_advance: expected %0d, got %0d", want.advance, byte_advance);
						err_cnt++;
					end
					if (next_offset !== want.offset) begin
						$error("next_offset: expected %0d, got %0d", want.offset, next_offset);
						err_cnt++;
					end
					if (status !== want.stat) begin
						$error("status: expected %0d, got %0d", want.stat, status);
						err_cnt++;
					end
				end
			end
			if (cfg_we) begin
				if (cfg_index == CFG_ENTRY_COUNT)
					active_count = cfg_data[COUNT_W-1:0];
				else
					search_len = cfg_data[LEN_W-1:0];
			end
			if (in_valid && !in_stall) begin
				if (opcode == OP_DECODE) begin
					symbol_q.push_back(lookup_symbol(window, bit_offset));
				end else begin
					want = '0;
					// overlong entry: flag it, keep the slot
					if (entry_length > LEN_W'(MAX_LEN))
						want.stat = STAT_LEN_ERR;
					else
						slots[entry_index] = '{code: entry_code, length: entry_length,
							value: entry_value};
					symbol_q.push_back(want);
				end
			end
		end
		errors  <= err_cnt;
		pending <= symbol_q.size();
	end

endmodule

/* dv/tb_vlc_table_symbol_decoder.sv */
`timescale 1ns / 1ps
// Testbench top for vlc_table_symbol_decoder: reset, config phases, load and decode
// words with random gaps and output stalls, watchdog and verdict. Uses vlcd_checker.
module tb_vlc_table_symbol_decoder import vlcd_pkg::*; ();

	localparam int RAND_ITEMS  = 650;
	localparam int DRAIN       = 300;
	localparam int QUIET_LIMIT = 4000;

	logic                    clk           = 1'b0;
	logic                    arst_n        = 1'b0;
	logic                    cfg_we        = 1'b0;
	logic [0:0]              cfg_index     = '0;
	logic [CFG_W-1:0]        cfg_data      = '0;
	logic                    in_valid      = 1'b0;
	logic                    in_stall;
	logic                    opcode        = 1'b0;
	logic [7:0]              entry_index   = '0;
	logic [CODE_W-1:0]       entry_code    = '0;
	logic [LEN_W-1:0]        entry_length  = '0;
	logic signed [VAL_W-1:0] entry_value   = '0;
	logic [31:0]             window        = '0;
	logic [2:0]              bit_offset    = '0;
	logic                    out_valid;
	logic                    out_stall     = 1'b0;
	logic signed [VAL_W-1:0] decoded_value;
	logic [LEN_W-1:0]        code_length;
	logic [2:0]              byte_advance;
	logic [2:0]              next_offset;
	logic [1:0]              status;
	int unsigned             errors;
	int unsigned             pending;

	entry_t shadow [TABLE_DEPTH];
	bit     filled [TABLE_DEPTH];
	int     cur_count;
	bit     pace       = 1'b1;
	int     sent       = 0;
	int     quiet      = 0;
	int     stall_hold = 0;

	vlc_table_symbol_decoder u_top (.*);

	vlcd_checker u_checker (.*);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic int gap_len();
		int r;
		if (!pace)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	always @(posedge clk) begin
		if (stall_hold != 0) begin
			stall_hold <= stall_hold - 1;
		end else begin
			stall_hold <= gap_len();
			out_stall  <= pace && ($urandom_range(0, 1) == 1);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic push_word(opcode_t op, logic [7:0] idx, logic [31:0] code, logic [5:0] len,
			logic [15:0] val, logic [31:0] win, logic [2:0] off);
		int gap;
		gap = gap_len();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		opcode       <= op;
		entry_index  <= idx;
		entry_code   <= code;
		entry_length <= len;
		entry_value  <= val;
		window       <= win;
		bit_offset   <= off;
		do @(posedge clk); while (in_stall !== 1'b0);
		sent++;
	endtask

	task automatic load_slot(logic [7:0] idx, logic [31:0] code, logic [5:0] len,
			logic [15:0] val);
		push_word(OP_LOAD, idx, code, len, val, $urandom, 3'($urandom_range(0, 7)));
		if (len <= MAX_LEN) begin
			shadow[idx] = '{code: code, length: len, value: val};
			filled[idx] = 1'b1;
		end
	endtask

	task automatic decode_at(logic [31:0] win, logic [2:0] off);
		push_word(OP_DECODE, 8'($urandom), $urandom, 6'($urandom), 16'($urandom), win, off);
	endtask

	task automatic load_random(logic [7:0] idx, bit allow_long);
		logic [5:0]  len;
		logic [31:0] code;
		int          r;
		r = $urandom_range(0, 99);
		if (allow_long && r < 10)
			len = 6'($urandom_range(33, 63));
		else if (r < 15)
			len = 6'd0;
		else if (r < 75)
			len = 6'($urandom_range(1, 8));
		else if (r < 95)
			len = 6'($urandom_range(9, 31));
		else
			len = 6'd32;
		code = $urandom;
		// mostly reachable codes, now and then stray bits above the length
		if (len < 32 && $urandom_range(0, 9) != 0)
			code &= (32'd1 << len) - 32'd1;
		load_slot(idx, code, len, 16'($urandom));
	endtask

	task automatic decode_aimed();
		int          slot;
		int          len;
		logic [2:0]  off;
		logic [31:0] aligned;
		logic [31:0] win;
		off = 3'($urandom_range(0, 7));
		win = $urandom;
		if (cur_count != 0) begin
			slot = $urandom_range(0, cur_count - 1);
			len  = shadow[slot].length;
			if (len != 0) begin
				aligned = (shadow[slot].code << (32 - len))
					| ($urandom & ((32'd1 << (32 - len)) - 32'd1));
				win = (aligned >> off) | ($urandom << (32 - off));
			end
		end
		decode_at(win, off);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic write_reg(cfg_index_t idx, int data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_W'(data);
		@(posedge clk);
		cfg_we    <= 1'b0;
		@(posedge clk);
	endtask

	task automatic start_phase(int count, int slen, bit idling);
		wait_idle();
		pace = idling;
		write_reg(CFG_ENTRY_COUNT, count);
		write_reg(CFG_SEARCH_LENGTH, slen);
		cur_count = (count > TABLE_DEPTH) ? TABLE_DEPTH : count;
		// fill every active slot before any decode reads it
		for (int i = 0; i < cur_count; i++)
			if (!filled[i])
				load_random(8'(i), 1'b0);
	endtask

	initial begin
		int r;
		int count;
		int slen;
		int n;
		int base;
		int phase;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		decode_at(32'hA000_0000, 3'd0);
		load_slot(8'd0, 32'h5, 6'd3, 16'h8000);
		load_slot(8'd1, 32'h1, 6'd2, 16'h7FFF);
		load_slot(8'd2, 32'hFFFF_FFFF, 6'd32, 16'hFFFF);
		load_slot(8'd3, 32'h0, 6'd0, 16'h0005);
		load_slot(8'd4, 32'h7, 6'd2, 16'h0007);
		load_slot(8'd5, 32'h1, 6'd2, 16'h0064);
		load_slot(8'd6, 32'h0, 6'd32, 16'h0001);
		load_slot(8'd7, 32'h0F0F, 6'd33, 16'h1111);
		load_slot(8'd7, 32'hFFFF_FFFF, 6'd63, 16'h2222);
		load_slot(8'd7, 32'h0F0F, 6'd16, 16'h5A5A);
		load_slot(8'd255, 32'h2A, 6'd6, 16'h1234);

		start_phase(8, 32, 1'b1);
		decode_at(32'hA000_0000, 3'd0);
		decode_at(32'h4000_0000, 3'd0);
		decode_at(32'hFFFF_FFFF, 3'd0);
		decode_at(32'hFFFF_FFFF, 3'd7);
		decode_at(32'h0000_0000, 3'd0);
		decode_at(32'h0000_0000, 3'd7);
		decode_at(32'h0F0F_0000, 3'd0);
		decode_at(32'h1400_0000, 3'd3);
		start_phase(8, 0, 1'b1);
		decode_at(32'hA000_0000, 3'd0);
		start_phase(8, 63, 1'b0);
		decode_at(32'h0000_0000, 3'd0);
		start_phase(8, 1, 1'b1);
		decode_at(32'h4000_0000, 3'd0);

		base  = sent;
		phase = 0;
		while (sent - base < RAND_ITEMS) begin
			phase++;
			r = $urandom_range(0, 99);
			if (phase == 3)
				count = TABLE_DEPTH;
			else if (phase == 7)
				count = 511;
			else if (r < 8)
				count = 0;
			else
				count = $urandom_range(1, 24);
			r = $urandom_range(0, 99);
			if (r < 8)
				slen = 32;
			else if (r < 12)
				slen = 63;
			else if (r < 15)
				slen = 0;
			else if (r < 22)
				slen = 1;
			else
				slen = $urandom_range(1, 32);
			start_phase(count, slen, $urandom_range(0, 3) != 0);
			n = (cur_count > 32) ? 8 : $urandom_range(15, 50);
			for (int k = 0; k < n; k++) begin
				r = $urandom_range(0, 99);
				if (r < 25) begin
					if (cur_count != 0 && $urandom_range(0, 9) < 7)
						load_random(8'($urandom_range(0, cur_count - 1)), 1'b1);
					else
						load_random(8'($urandom_range(0, 255)), 1'b1);
				end else if (r < 85) begin
					decode_aimed();
				end else begin
					decode_at($urandom, 3'($urandom_range(0, 7)));
				end
			end
		end

		wait_idle();
		repeat (DRAIN) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
